>>> sv/dense_slot_map_core_defines.svh
// ---------------------------------------------------------------------------
// dense_slot_map_core_defines
// Assertion macros shared by the slot map RTL.
// ---------------------------------------------------------------------------
`ifndef DENSE_SLOT_MAP_CORE_DEFINES_SVH
`define DENSE_SLOT_MAP_CORE_DEFINES_SVH

// same-cycle implication, checked on clock, quiet during reset
`define DSM_ASSERT_NOW(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("slot map check failed");

// next-cycle implication, checked on clock, quiet during reset
`define DSM_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("slot map check failed");

`endif

>>> sv/dsm_pkg.sv
// ---------------------------------------------------------------------------
// dsm_pkg
// Shared constants and codes for the dense slot map.
// ---------------------------------------------------------------------------
package dsm_pkg;

   localparam int TABLE_ENTRIES_DEF = 256;
   localparam int WORD_BITS_DEF     = 32;

   localparam int OPCODE_BITS = 2;
   localparam int HANDLE_BITS = 8;
   localparam int WORD_PORT_BITS = 32;
   localparam int COUNT_PORT_BITS = 9;
   localparam int STATUS_BITS = 2;

   typedef logic [OPCODE_BITS-1:0] opcode_type;
   typedef logic [STATUS_BITS-1:0] status_type;

   localparam opcode_type OP_ADD    = 2'd0;
   localparam opcode_type OP_REMOVE = 2'd1;
   localparam opcode_type OP_GET    = 2'd2;
   localparam opcode_type OP_CLEAR  = 2'd3;

   localparam status_type ST_OK   = 2'd0;
   localparam status_type ST_FULL = 2'd1;
   localparam status_type ST_BAD  = 2'd2;

endpackage

>>> sv/dsm_ram.sv
// ---------------------------------------------------------------------------
// dsm_ram
// Generic RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module dsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/dense_slot_map_core.sv
// ---------------------------------------------------------------------------
// dense_slot_map_core
// Handle table with densely packed data words and a recycled-handle list.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result appears
// on the rsp_ ports for one cycle, marked by rsp_valid, in the cycle after the
// last work cycle, and the receiver cannot stall it. Clear, add of a fresh
// handle, full add and remove/get of a never-issued handle end in S_IDLE; add
// of a recycled handle goes on to S_LINK, get or remove of an issued but freed
// handle to S_CODE, and get or remove of a live handle to S_CODE, then S_DATA or
// S_MOVE. The steps are set by the dependent reads of the two single-read-port
// memories: the handle map (slot code plus free-list link) and the slot map
// (owner handle plus data word). Freed handles form a LIFO list linked
// through the handle map. No clearing pass follows reset.
// ---------------------------------------------------------------------------
`include "dense_slot_map_core_defines.svh"

module dense_slot_map_core
   import dsm_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int WORD_BITS     = WORD_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [OPCODE_BITS-1:0]     req_opcode,
   input  logic [HANDLE_BITS-1:0]     req_handle,
   input  logic [WORD_PORT_BITS-1:0]  req_write_word,
   output logic                       rsp_valid,
   output logic [HANDLE_BITS-1:0]     rsp_assigned_handle,
   output logic [WORD_PORT_BITS-1:0]  rsp_read_word,
   output logic [COUNT_PORT_BITS-1:0] rsp_live_count,
   output logic [STATUS_BITS-1:0]     rsp_status
);

   localparam int HW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int H_BITS = HW + CW;
   localparam int S_BITS = HW + WORD_BITS;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LINK = 3'd1;
   localparam logic [2:0] S_CODE = 3'd2;
   localparam logic [2:0] S_DATA = 3'd3;
   localparam logic [2:0] S_MOVE = 3'd4;

   logic [2:0]           state_ff, state_in;
   opcode_type           op_ff, op_in;
   logic [HW-1:0]        handle_ff, handle_in;
   logic [WORD_BITS-1:0] word_ff, word_in;
   logic [HW-1:0]        top_ff, top_in;
   logic [CW-1:0]        depth_ff, depth_in;
   logic [CW-1:0]        issued_ff, issued_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [HW-1:0]        slot_ff, slot_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_BITS-1:0]     rsp_handle_ff, rsp_handle_in;
   logic [WORD_PORT_BITS-1:0]  rsp_word_ff, rsp_word_in;
   logic [COUNT_PORT_BITS-1:0] rsp_count_ff, rsp_count_in;
   status_type                 rsp_status_ff, rsp_status_in;

   logic              h_we;
   logic [HW-1:0]     h_waddr, h_raddr;
   logic [H_BITS-1:0] h_wdata, h_rdata;
   logic              s_we;
   logic [HW-1:0]     s_waddr, s_raddr;
   logic [S_BITS-1:0] s_wdata, s_rdata;

   logic [CW-1:0] code;
   logic [HW-1:0] link;

   assign code = h_rdata[CW-1:0];
   assign link = h_rdata[CW +: HW];

   dsm_ram #(.WIDTH(H_BITS), .DEPTH(TABLE_ENTRIES)) u_handle_map (
      .clock   (clock),
      .wr_en   (h_we),
      .wr_addr (h_waddr),
      .wr_data (h_wdata),
      .rd_addr (h_raddr),
      .rd_data (h_rdata)
   );

   dsm_ram #(.WIDTH(S_BITS), .DEPTH(TABLE_ENTRIES)) u_slot_map (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      handle_in = handle_ff;
      word_in   = word_ff;
      top_in    = top_ff;
      depth_in  = depth_ff;
      issued_in = issued_ff;
      count_in  = count_ff;
      slot_in   = slot_ff;

      rsp_valid_in  = 1'b0;
      rsp_handle_in = '0;
      rsp_word_in   = '0;
      rsp_count_in  = COUNT_PORT_BITS'(count_ff);
      rsp_status_in = ST_OK;

      h_we    = 1'b0;
      h_waddr = '0;
      h_wdata = '0;
      h_raddr = handle_ff;
      s_we    = 1'b0;
      s_waddr = '0;
      s_wdata = '0;
      s_raddr = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in     = req_opcode;
               handle_in = HW'(req_handle);
               word_in   = WORD_BITS'(req_write_word);
               case (req_opcode)
                  OP_ADD: begin
                     if (depth_ff != '0) begin
                        h_raddr  = top_ff;
                        state_in = S_LINK;
                     end else if (issued_ff == CW'(TABLE_ENTRIES)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_FULL;
                     end else begin
                        h_we          = 1'b1;
                        h_waddr       = HW'(issued_ff);
                        h_wdata       = {top_ff, count_ff + CW'(1)};
                        s_we          = 1'b1;
                        s_waddr       = HW'(count_ff);
                        s_wdata       = {HW'(issued_ff), WORD_BITS'(req_write_word)};
                        issued_in     = issued_ff + CW'(1);
                        count_in      = count_ff + CW'(1);
                        rsp_valid_in  = 1'b1;
                        rsp_handle_in = HANDLE_BITS'(issued_ff);
                        rsp_count_in  = COUNT_PORT_BITS'(count_ff + CW'(1));
                     end
                  end
                  OP_REMOVE, OP_GET: begin
                     if (32'(req_handle) >= 32'(issued_ff)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_BAD;
                     end else begin
                        h_raddr  = HW'(req_handle);
                        state_in = S_CODE;
                     end
                  end
                  default: begin
                     issued_in     = '0;
                     count_in      = '0;
                     depth_in      = '0;
                     rsp_valid_in  = 1'b1;
                     rsp_count_in  = '0;
                  end
               endcase
            end
         end
         S_LINK: begin
            h_we          = 1'b1;
            h_waddr       = top_ff;
            h_wdata       = {top_ff, count_ff + CW'(1)};
            s_we          = 1'b1;
            s_waddr       = HW'(count_ff);
            s_wdata       = {top_ff, word_ff};
            top_in        = link;
            depth_in      = depth_ff - CW'(1);
            count_in      = count_ff + CW'(1);
            rsp_valid_in  = 1'b1;
            rsp_handle_in = HANDLE_BITS'(top_ff);
            rsp_count_in  = COUNT_PORT_BITS'(count_ff + CW'(1));
            state_in      = S_IDLE;
         end
         S_CODE: begin
            if (code == '0 || code > count_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_BAD;
               state_in      = S_IDLE;
            end else if (op_ff == OP_GET) begin
               s_raddr  = HW'(code - CW'(1));
               state_in = S_DATA;
            end else begin
               s_raddr  = HW'(count_ff - CW'(1));
               h_we     = 1'b1;
               h_waddr  = handle_ff;
               h_wdata  = {top_ff, CW'(0)};
               top_in   = handle_ff;
               depth_in = depth_ff + CW'(1);
               count_in = count_ff - CW'(1);
               slot_in  = HW'(code - CW'(1));
               state_in = S_MOVE;
            end
         end
         S_DATA: begin
            rsp_valid_in = 1'b1;
            rsp_word_in  = WORD_PORT_BITS'(s_rdata[WORD_BITS-1:0]);
            state_in     = S_IDLE;
         end
         S_MOVE: begin
            if (CW'(slot_ff) != count_ff) begin
               s_we    = 1'b1;
               s_waddr = slot_ff;
               s_wdata = s_rdata;
               h_we    = 1'b1;
               h_waddr = s_rdata[WORD_BITS +: HW];
               h_wdata = {top_ff, CW'(slot_ff) + CW'(1)};
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         top_ff       <= '0;
         depth_ff     <= '0;
         issued_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         depth_ff     <= depth_in;
         issued_ff    <= issued_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      handle_ff     <= handle_in;
      word_ff       <= word_in;
      slot_ff       <= slot_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_assigned_handle = rsp_handle_ff;
   assign rsp_read_word       = rsp_word_ff;
   assign rsp_live_count      = rsp_count_ff;
   assign rsp_status          = rsp_status_ff;

   `DSM_ASSERT_NOW(a_handles_balance, 1'b1, 32'(count_ff) + 32'(depth_ff) == 32'(issued_ff))
   `DSM_ASSERT_NOW(a_issued_bound, 1'b1, 32'(issued_ff) <= TABLE_ENTRIES)
   `DSM_ASSERT_NEXT(a_move_answers, state_ff == S_MOVE, rsp_valid_ff && !busy)
   `DSM_ASSERT_NOW(a_move_slot_live, state_ff == S_MOVE, 32'(slot_ff) <= 32'(count_ff))
   `DSM_ASSERT_NOW(a_link_pops, state_ff == S_LINK, depth_ff != '0)

endmodule
